/* hw/rtl/psls_pkg.sv */
`default_nettype none

package psls_pkg;

	// Field widths
	localparam int unsigned SRC_W  = 3;
	localparam int unsigned CNT_W  = 32;
	localparam int unsigned TOT_W  = 48;

	// Stream payload layout
	localparam int unsigned IN_FIELD_W  = SRC_W + CNT_W;
	localparam int unsigned IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
	localparam int unsigned OUT_FIELD_W = SRC_W + 5 * CNT_W;
	localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	// Divider: one quotient bit per step over the whole total
	localparam int unsigned DIV_STEPS = TOT_W;
	localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

	// Event kinds carried on tuser
	localparam logic REQ_MADE  = 1'b0;
	localparam logic REQ_EATEN = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_DONE
	} state_t;

	// One statistics entry
	typedef struct packed {
		logic [TOT_W-1:0] total;
		logic [CNT_W-1:0] max_dly;
		logic [CNT_W-1:0] min_dly;
		logic [CNT_W-1:0] eaten;
		logic [CNT_W-1:0] made;
	} entry_t;

	localparam entry_t ENTRY_RST = '{
		total:   '0,
		max_dly: '0,
		min_dly: '1,
		eaten:   '0,
		made:    '0
	};

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (&v) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/per_source_latency_stats.sv */
// Per-source latency statistics.
//
// Input stream (s_axis_*): one event per transfer. tuser selects a produced
// event (0) or a consumed event (1); tdata carries the source index and,
// for consumed events, the delay. Output stream (m_axis_*): one result per
// event with the updated entry of that source, its truncated average delay
// and a flag in tuser when the made and eaten counts differ.
//
// Each event passes these steps from accept to result: the table is read at
// the accept edge, then the entry is updated and written back (ST_UPD), the
// divider gives one quotient bit per cycle of the 48-bit total (ST_DIV), and
// the output register is loaded once it is free (ST_DONE). Events whose entry
// has no consumed item yet, or whose source index is NUM_SOURCES or above,
// skip the divider. s_axis_tready is high only while idle, so a new event is
// accepted only after the previous result has been loaded for output.
//
// Reset clears the valid bit of every table entry, so every source reads
// as an empty entry; no clearing pass is needed. If the receiver stalls,
// the result waits in the output register; one further event is accepted
// and processed, and its result waits until the register is free.
`default_nettype none

module per_source_latency_stats
	import psls_pkg::*;
#(
	parameter int unsigned NUM_SOURCES = 8
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// tdata: source_id[2:0], delay[34:3], zero pad
	input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
	// tuser: req_type
	input  wire                    s_axis_tuser,
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: out_source[2:0], made_count[34:3], eaten_count[66:35],
	//        min_latency[98:67], max_latency[130:99], avg_latency[162:131], zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// tuser: mismatch
	output logic                   m_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready
);

	localparam int unsigned IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

	// Input field split
	logic [SRC_W-1:0] in_src;
	logic [CNT_W-1:0] in_delay;
	logic [IDX_W-1:0] in_idx;
	logic             in_xfer;

	assign in_src   = s_axis_tdata[SRC_W-1:0];
	assign in_delay = s_axis_tdata[SRC_W +: CNT_W];
	assign in_idx   = IDX_W'(in_src);
	assign in_xfer  = s_axis_tvalid && s_axis_tready;

	// Sequencer
	state_t state_q, state_d;
	logic   load_out;
	logic   out_free;

	// Captured event
	logic             kind_q;
	logic [SRC_W-1:0] src_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] delay_q;
	logic             oor_q;

	// Table storage and valid bits
	entry_t                 stat_mem_q [NUM_SOURCES];
	logic [NUM_SOURCES-1:0] vld_q;
	entry_t                 rd_entry_q;
	logic                   rd_vld_q;

	// Updated entry
	entry_t           cur_entry;
	entry_t           upd_entry;
	logic [TOT_W:0]   tot_sum;

	// Result fields held while the divider runs
	entry_t     res_q;
	logic       mis_q;

	// Divider registers
	logic [TOT_W-1:0]  dq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;

	// Output register
	logic [SRC_W-1:0] o_src_q;
	entry_t           o_ent_q;
	logic [CNT_W-1:0] o_avg_q;
	logic             o_mis_q;
	logic             o_vld_q;

	assign out_free = !o_vld_q || m_axis_tready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (oor_q || (upd_entry.eaten == '0)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Entry update: counters, saturating total, min and max
	always_comb begin
		cur_entry = rd_vld_q ? rd_entry_q : ENTRY_RST;
		upd_entry = cur_entry;
		tot_sum   = {1'b0, cur_entry.total} + (TOT_W + 1)'(delay_q);
		if (kind_q == REQ_MADE) begin
			upd_entry.made = sat_inc(cur_entry.made);
		end else begin
			upd_entry.eaten = sat_inc(cur_entry.eaten);
			upd_entry.total = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
			if (delay_q <= cur_entry.min_dly) begin
				upd_entry.min_dly = delay_q;
			end
			if (delay_q >= cur_entry.max_dly) begin
				upd_entry.max_dly = delay_q;
			end
		end
	end

	// Event capture and table read
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q     <= s_axis_tuser;
			src_q      <= in_src;
			idx_q      <= in_idx;
			delay_q    <= in_delay;
			oor_q      <= (32'(in_src) >= NUM_SOURCES);
			rd_entry_q <= stat_mem_q[in_idx];
			rd_vld_q   <= vld_q[in_idx];
		end
	end

	// Table write back
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD && !oor_q) begin
			stat_mem_q[idx_q] <= upd_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (state_q == ST_UPD && !oor_q) begin
			vld_q[idx_q] <= 1'b1;
		end
	end

	// Result hold and divider operand load
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			if (oor_q) begin
				res_q <= ENTRY_RST;
				mis_q <= 1'b0;
			end else begin
				res_q <= upd_entry;
				mis_q <= (upd_entry.made != upd_entry.eaten);
			end
		end
	end

	// Shared restoring divider: total / eaten, one quotient bit per cycle
	logic [CNT_W:0] rem_sh;
	logic [CNT_W:0] rem_sub;

	assign rem_sh  = {rem_q, dq_q[TOT_W-1]};
	assign rem_sub = rem_sh - {1'b0, res_q.eaten};

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			// zero dividend gives a zero average where no divide runs
			dq_q  <= (oor_q || (upd_entry.eaten == '0)) ? '0 : upd_entry.total;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			if (!rem_sub[CNT_W]) begin
				rem_q <= rem_sub[CNT_W-1:0];
				dq_q  <= {dq_q[TOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CNT_W-1:0];
				dq_q  <= {dq_q[TOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			cnt_q <= cnt_q + DCNT_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// Output register, average clamped to 32 bits
	always_ff @(posedge clk) begin
		if (load_out) begin
			o_src_q <= src_q;
			o_ent_q <= res_q;
			o_mis_q <= mis_q;
			o_avg_q <= (|dq_q[TOT_W-1:CNT_W]) ? '1 : dq_q[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q <= 1'b0;
		end else if (load_out) begin
			o_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			o_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = o_vld_q;
	assign m_axis_tuser  = o_mis_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, o_avg_q, o_ent_q.max_dly, o_ent_q.min_dly,
		o_ent_q.eaten, o_ent_q.made, o_src_q};

	// Checks
	a_accept_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_UPD)
		else $error("accepted event did not move to update");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && !oor_q) |=> vld_q[$past(idx_q)])
		else $error("written entry not marked valid");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < DCNT_W'(DIV_STEPS))
		else $error("divider ran past its step count");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(o_vld_q && o_ent_q.eaten != '0) |-> o_ent_q.min_dly <= o_ent_q.max_dly)
		else $error("minimum delay above maximum delay");

endmodule

`default_nettype wire

/* tb/per_source_latency_stats_tb.sv */
`default_nettype none

module per_source_latency_stats_tb;
	import psls_pkg::*;

	localparam int unsigned SOURCES      = 8;
	localparam int unsigned LIMIT_CYCLES = 600000;
	localparam int unsigned RANDOM_ITEMS = 1530;
	localparam int unsigned DRAIN_CYCLES = 120;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned MAX_PRINTS   = 100;

	// Expected content of one output transfer
	typedef struct packed {
		logic [SRC_W-1:0] src;
		logic [CNT_W-1:0] made;
		logic [CNT_W-1:0] eaten;
		logic [CNT_W-1:0] min_dly;
		logic [CNT_W-1:0] max_dly;
		logic [CNT_W-1:0] avg_dly;
		logic             differ;
	} stats_entry_t;

	// Statistics predictor and queue of pending entries
	class latency_board;
		logic [CNT_W-1:0] made_tbl  [SOURCES];
		logic [CNT_W-1:0] eaten_tbl [SOURCES];
		logic [CNT_W-1:0] min_tbl   [SOURCES];
		logic [CNT_W-1:0] max_tbl   [SOURCES];
		logic [TOT_W-1:0] total_tbl [SOURCES];
		stats_entry_t     pending_entries [$];
		int               errors;

		function new();
			errors = 0;
			for (int i = 0; i < SOURCES; i++) begin
				made_tbl[i]  = '0;
				eaten_tbl[i] = '0;
				min_tbl[i]   = '1;
				max_tbl[i]   = '0;
				total_tbl[i] = '0;
			end
		endfunction

		function int pending();
			return pending_entries.size();
		endfunction

		task report_mismatch(input string what);
			if (errors < MAX_PRINTS)
				$display("[%0t] mismatch: %s", $time, what);
			errors++;
		endtask

		// Apply one accepted event and queue the entry it should produce
		function void note_event(input logic kind, input logic [SRC_W-1:0] src,
				input logic [CNT_W-1:0] dly);
			stats_entry_t     e;
			logic [TOT_W:0]   sum;
			logic [TOT_W-1:0] quot;
			e.src = src;
			if (src >= SOURCES) begin
				e.made    = '0;
				e.eaten   = '0;
				e.min_dly = '1;
				e.max_dly = '0;
				e.avg_dly = '0;
				e.differ  = 1'b0;
			end else begin
				if (kind == REQ_MADE) begin
					if (!(&made_tbl[src]))
						made_tbl[src] = made_tbl[src] + 1'b1;
				end else begin
					if (!(&eaten_tbl[src]))
						eaten_tbl[src] = eaten_tbl[src] + 1'b1;
					sum = {1'b0, total_tbl[src]} + dly;
					total_tbl[src] = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
					// min and max are updated independently
					if (dly <= min_tbl[src])
						min_tbl[src] = dly;
					if (dly >= max_tbl[src])
						max_tbl[src] = dly;
				end
				e.made    = made_tbl[src];
				e.eaten   = eaten_tbl[src];
				e.min_dly = min_tbl[src];
				e.max_dly = max_tbl[src];
				if (eaten_tbl[src] == '0) begin
					e.avg_dly = '0;
				end else begin
					quot = total_tbl[src] / TOT_W'(eaten_tbl[src]);
					e.avg_dly = (quot > TOT_W'({CNT_W{1'b1}})) ? '1 : quot[CNT_W-1:0];
				end
				e.differ = (made_tbl[src] != eaten_tbl[src]);
			end
			pending_entries.push_back(e);
		endfunction

		task compare_field(input string name, input logic [CNT_W-1:0] got,
				input logic [CNT_W-1:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %h want %h", name, got, want));
		endtask

		// Compare one output transfer against the oldest pending entry
		task check_entry(input logic [OUT_TDATA_W-1:0] data, input logic flag);
			stats_entry_t e;
			if (pending_entries.size() == 0) begin
				report_mismatch("output transfer with nothing pending");
			end else begin
				e = pending_entries.pop_front();
				compare_field("out_source", CNT_W'(data[SRC_W-1:0]), CNT_W'(e.src));
				compare_field("made_count",  data[SRC_W+0*CNT_W +: CNT_W], e.made);
				compare_field("eaten_count", data[SRC_W+1*CNT_W +: CNT_W], e.eaten);
				compare_field("min_latency", data[SRC_W+2*CNT_W +: CNT_W], e.min_dly);
				compare_field("max_latency", data[SRC_W+3*CNT_W +: CNT_W], e.max_dly);
				compare_field("avg_latency", data[SRC_W+4*CNT_W +: CNT_W], e.avg_dly);
				compare_field("mismatch", CNT_W'(flag), CNT_W'(e.differ));
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;

	latency_board     board = new();
	int unsigned      cycles = 0;
	int unsigned      results_seen = 0;
	bit               tx_calm = 1'b0;
	logic [CNT_W-1:0] recent_dly [SOURCES];

	per_source_latency_stats #(
		.NUM_SOURCES(SOURCES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one event; returns right after the accepting edge.
	// tvalid stays high into the next call when no gap is drawn.
	task automatic send_event(input logic kind, input logic [SRC_W-1:0] src,
			input logic [CNT_W-1:0] dly);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= IN_TDATA_W'({dly, src});
		s_axis_tuser  <= kind;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		board.note_event(kind, src, dly);
		if (kind == REQ_EATEN)
			recent_dly[src] = dly;
	endtask

	function automatic logic [CNT_W-1:0] pick_delay(input logic [SRC_W-1:0] src);
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return '1;
			2:       return recent_dly[src];
			3, 4:    return CNT_W'($urandom_range(0, 2000));
			5:       return {1'b1, 31'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// Receiver: random stalls, calm stretches and two long hold-offs
	initial begin
		int unsigned gap;
		bit          rx_calm;
		rx_calm = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (results_seen % 50 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (results_seen == 25 || results_seen == 900)
				gap = HOLD_CYCLES;
			else
				gap = rx_calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			board.check_entry(m_axis_tdata, m_axis_tuser);
			results_seen++;
		end
	end

	// Reset, directed events, random episodes, drain
	initial begin
		int unsigned      sent;
		int unsigned      n;
		logic [SRC_W-1:0] src;
		logic             kind;

		arst_n        = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_MADE;
		s_axis_tvalid = 1'b0;
		for (int i = 0; i < SOURCES; i++)
			recent_dly[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty entry: all-ones delay keeps the minimum at all ones, sets max
		send_event(REQ_EATEN, 3'd0, 32'hFFFF_FFFF);
		send_event(REQ_EATEN, 3'd0, 32'h0000_0000);
		send_event(REQ_EATEN, 3'd0, 32'hFFFF_FFFF);
		send_event(REQ_EATEN, 3'd0, 32'hFFFF_FFFF);
		// Produced events ignore the delay field
		send_event(REQ_MADE,  3'd1, 32'hA5A5_5A5A);
		send_event(REQ_MADE,  3'd1, 32'h5A5A_A5A5);
		send_event(REQ_EATEN, 3'd1, 32'd100);
		send_event(REQ_EATEN, 3'd1, 32'd100);
		send_event(REQ_EATEN, 3'd1, 32'd7);
		// First consumed delay sets both min and max
		send_event(REQ_EATEN, 3'd7, 32'h8000_0000);
		send_event(REQ_EATEN, 3'd7, 32'h7FFF_FFFF);
		send_event(REQ_EATEN, 3'd7, 32'h8000_0001);
		send_event(REQ_MADE,  3'd7, 32'hFFFF_FFFF);
		for (int i = 0; i < SOURCES; i++)
			send_event(REQ_MADE, SRC_W'(i), 32'hFFFF_FFFF);

		// Random part: mostly balanced produce/consume runs per source
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 64 < 4)
				tx_calm = ($urandom_range(0, 3) == 0);
			n   = $urandom_range(1, 6);
			src = SRC_W'($urandom_range(0, SOURCES - 1));
			if ($urandom_range(0, 4) != 0) begin
				for (int i = 0; i < n; i++)
					send_event(REQ_MADE, src, $urandom);
				for (int i = 0; i < n; i++)
					send_event(REQ_EATEN, src, pick_delay(src));
				sent += 2 * n;
			end else begin
				for (int i = 0; i < n; i++) begin
					src  = SRC_W'($urandom_range(0, SOURCES - 1));
					kind = $urandom_range(0, 1) ? REQ_EATEN : REQ_MADE;
					send_event(kind, src, pick_delay(src));
				end
				sent += n;
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.pending() != 0)
			board.report_mismatch("entries still pending at end of run");
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
